/* sv/fis_pkg.sv */
// ----------------------------------------------------------------------------
// fis_pkg
// Shared types and constants for the burner ignition sequencer.
// ----------------------------------------------------------------------------
package fis_pkg;

  localparam int LIMIT_WIDTH     = 8;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 8;
  localparam int IN_DATA_WIDTH   = 8;
  localparam int OUT_DATA_WIDTH  = 16;
  localparam int PHASE_WIDTH     = 3;

  localparam logic [LIMIT_WIDTH-1:0] INDUCER_LIMIT_RESET = 8'd5;
  localparam logic [LIMIT_WIDTH-1:0] IGNITOR_LIMIT_RESET = 8'd15;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INDUCER_LIMIT = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IGNITOR_LIMIT = 8'd1;

  localparam logic [PHASE_WIDTH-1:0] PHASE_IDLE     = 3'd0;
  localparam logic [PHASE_WIDTH-1:0] PHASE_PRESSURE = 3'd1;
  localparam logic [PHASE_WIDTH-1:0] PHASE_WARMUP   = 3'd2;
  localparam logic [PHASE_WIDTH-1:0] PHASE_START    = 3'd3;
  localparam logic [PHASE_WIDTH-1:0] PHASE_BURNING  = 3'd4;

  typedef logic [LIMIT_WIDTH-1:0] limit_t;
  typedef logic [PHASE_WIDTH-1:0] phase_t;

  typedef struct packed {
    limit_t seconds_left;
    phase_t phase_code;
    logic   running;
    logic   blower_on;
    logic   gas_valve_open;
    logic   ignitor_on;
    logic   inducer_on;
  } result_t;

endpackage

/* sv/furnace_ignition_sequencer_core.sv */
// ----------------------------------------------------------------------------
// furnace_ignition_sequencer_core
// A result appears on the master side in the cycle after its accept.
// One request per cycle while m_tready is high; sole stage: output register.
// s_tready stays high while the output register is empty or being drained.
// Reset: run flag and timers clear, limits return to 5 s and 15 s,
// the button and flame history read as released and no flame.
// ----------------------------------------------------------------------------
module furnace_ignition_sequencer_core #(
  parameter int SECONDS_WIDTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] button_level, [1] pressure_level, [2] flame_level, [3] second_tick
  input  logic [fis_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] inducer_on, [1] ignitor_on, [2] gas_valve_open, [3] blower_on,
  // [4] running, [7:5] phase_code, [15:8] seconds_left
  output logic [fis_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fis_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [fis_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int CW = (SECONDS_WIDTH > fis_pkg::LIMIT_WIDTH) ?
                      SECONDS_WIDTH : fis_pkg::LIMIT_WIDTH;

  typedef logic [SECONDS_WIDTH-1:0] sec_t;
  typedef logic [CW-1:0]            cmp_t;

  fis_pkg::limit_t inducer_limit;
  fis_pkg::limit_t ignitor_limit;

  logic run_flag;
  logic last_button;
  logic last_flame;
  logic last_gas_open;
  logic last_ignitor_on;
  logic inducer_started;
  sec_t inducer_seconds;
  logic ignitor_started;
  sec_t ignitor_seconds;

  logic              out_valid;
  fis_pkg::result_t  out_data;

  logic run_flag_next;
  logic inducer_started_next;
  sec_t inducer_seconds_next;
  logic ignitor_started_next;
  sec_t ignitor_seconds_next;
  fis_pkg::result_t  result;

  logic btn, pres, flame_lvl, flame, tick, accept;
  sec_t ind_t, ign_t, ign_cur;
  cmp_t ind_cmp, ign_cmp, ind_lim_cmp, ign_lim_cmp, ign_half_cmp;
  fis_pkg::limit_t ign_half;
  logic run0, ind_ok, ign_ok, ind_on, ign_on, gas, blower;

  assign btn       = s_tdata[0];
  assign pres      = s_tdata[1];
  assign flame_lvl = s_tdata[2];
  assign tick      = s_tdata[3];
  assign flame     = ~flame_lvl;

  assign s_tready  = ~out_valid | m_tready;
  assign accept    = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  assign ign_half     = ignitor_limit >> 1;
  assign ind_lim_cmp  = cmp_t'(inducer_limit);
  assign ign_lim_cmp  = cmp_t'(ignitor_limit);
  assign ign_half_cmp = cmp_t'(ign_half);

  always_comb begin
    ind_t = inducer_seconds;
    if (tick && inducer_started && (inducer_seconds != '1)) begin
      ind_t = inducer_seconds + sec_t'(1);
    end
    ign_t = ignitor_seconds;
    if (tick && ignitor_started && (ignitor_seconds != '1)) begin
      ign_t = ignitor_seconds + sec_t'(1);
    end

    run0    = run_flag ^ (last_button & ~btn);
    ind_cmp = cmp_t'(ind_t);
    ind_ok  = ~inducer_started | (ind_cmp < ind_lim_cmp) | pres;
    ind_on  = run0 & ind_ok;

    ign_cmp = cmp_t'(ign_t);
    ign_ok  = ind_on & pres & (~ignitor_started | (ign_cmp < ign_lim_cmp));
    ign_on  = ign_ok;
    ign_cur = (ign_ok & ~ignitor_started) ? '0 : ign_t;

    gas    = run0 & pres & ((ign_on & (cmp_t'(ign_cur) > ign_half_cmp)) | flame);
    blower = run0 & pres & flame;

    run_flag_next = run0 & ind_ok;
    if (run0 && !gas && last_gas_open) begin
      run_flag_next = 1'b0;
    end
    if (last_gas_open && !last_ignitor_on && !flame) begin
      run_flag_next = 1'b0;
    end
    if (!last_flame && !flame) begin
      run_flag_next = 1'b0;
    end

    inducer_started_next = inducer_started | ind_on;
    inducer_seconds_next = inducer_started ? ind_t : '0;
    ignitor_started_next = ignitor_started | ign_ok;
    ignitor_seconds_next = ign_cur;

    if (!run_flag_next) begin
      ind_on               = 1'b0;
      ign_on               = 1'b0;
      gas                  = 1'b0;
      blower               = 1'b0;
      inducer_started_next = 1'b0;
      inducer_seconds_next = '0;
      ignitor_started_next = 1'b0;
      ignitor_seconds_next = '0;
    end

    result.inducer_on     = ind_on;
    result.ignitor_on     = ign_on;
    result.gas_valve_open = gas;
    result.blower_on      = blower;
    result.running        = run_flag_next;
    result.phase_code     = fis_pkg::PHASE_IDLE;
    result.seconds_left   = '0;
    if (ind_on && !pres) begin
      result.phase_code = fis_pkg::PHASE_PRESSURE;
      if (cmp_t'(inducer_seconds_next) < ind_lim_cmp) begin
        result.seconds_left = inducer_limit - fis_pkg::limit_t'(inducer_seconds_next);
      end
    end else if (ign_on && !gas) begin
      result.phase_code = fis_pkg::PHASE_WARMUP;
      if (cmp_t'(ignitor_seconds_next) < ign_half_cmp) begin
        result.seconds_left = ign_half - fis_pkg::limit_t'(ignitor_seconds_next);
      end
    end else if (ign_on && gas && !flame) begin
      result.phase_code = fis_pkg::PHASE_START;
      if (cmp_t'(ignitor_seconds_next) < ign_lim_cmp) begin
        result.seconds_left = ignitor_limit - fis_pkg::limit_t'(ignitor_seconds_next);
      end
    end else if (pres && flame && blower && gas) begin
      result.phase_code = fis_pkg::PHASE_BURNING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inducer_limit   <= fis_pkg::INDUCER_LIMIT_RESET;
      ignitor_limit   <= fis_pkg::IGNITOR_LIMIT_RESET;
      run_flag        <= 1'b0;
      last_button     <= 1'b1;
      last_flame      <= 1'b1;
      last_gas_open   <= 1'b0;
      last_ignitor_on <= 1'b0;
      inducer_started <= 1'b0;
      inducer_seconds <= '0;
      ignitor_started <= 1'b0;
      ignitor_seconds <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fis_pkg::REG_INDUCER_LIMIT: inducer_limit <= cfg_data;
          fis_pkg::REG_IGNITOR_LIMIT: ignitor_limit <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        run_flag        <= run_flag_next;
        last_button     <= btn;
        last_flame      <= flame_lvl;
        last_gas_open   <= result.gas_valve_open;
        last_ignitor_on <= result.ignitor_on;
        inducer_started <= inducer_started_next;
        inducer_seconds <= inducer_seconds_next;
        ignitor_started <= ignitor_started_next;
        ignitor_seconds <= ignitor_seconds_next;
        out_valid       <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted request produced no result");

  a_stopped_timers_clear: assert property (@(posedge clk) disable iff (rst)
    !run_flag |-> (!inducer_started && !ignitor_started &&
                   inducer_seconds == '0 && ignitor_seconds == '0))
    else $error("timers active while stopped");

  a_gas_needs_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.gas_valve_open |-> out_data.running && out_data.inducer_on)
    else $error("gas open without run flag and inducer");

  a_burning_relays: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.phase_code == fis_pkg::PHASE_BURNING |->
      out_data.blower_on && out_data.gas_valve_open && out_data.seconds_left == '0)
    else $error("burning phase with wrong relays");

  a_ignitor_needs_start: assert property (@(posedge clk) disable iff (rst)
    accept && result.ignitor_on |=> ignitor_started && inducer_started)
    else $error("ignitor on without started timers");

endmodule

/* dv/tb_furnace_ignition_sequencer_core.sv */
// ----------------------------------------------------------------------------
// tb_furnace_ignition_sequencer_core
// Self-checking bench for the burner ignition sequencer. A short directed
// ignition run is followed by randomized ignition attempts, faults and pin
// noise under several limit settings. The expected relay state is predicted
// per request and compared field by field, with random gaps and back-pressure
// on both streams.
// ----------------------------------------------------------------------------
module tb_furnace_ignition_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECONDS_WIDTH  = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  class relay_scoreboard;
    fis_pkg::limit_t          inducer_limit;
    fis_pkg::limit_t          ignitor_limit;
    logic                     run_flag;
    logic                     last_button;
    logic                     last_flame_lvl;
    logic                     last_gas_open;
    logic                     last_ignitor_on;
    logic                     inducer_started;
    logic                     ignitor_started;
    logic [SECONDS_WIDTH-1:0] inducer_secs;
    logic [SECONDS_WIDTH-1:0] ignitor_secs;
    fis_pkg::result_t         expected_relays[$];
    int                       mismatches;

    function new();
      inducer_limit   = fis_pkg::INDUCER_LIMIT_RESET;
      ignitor_limit   = fis_pkg::IGNITOR_LIMIT_RESET;
      run_flag        = 1'b0;
      last_button     = 1'b1;
      last_flame_lvl  = 1'b1;
      last_gas_open   = 1'b0;
      last_ignitor_on = 1'b0;
      inducer_started = 1'b0;
      ignitor_started = 1'b0;
      inducer_secs    = '0;
      ignitor_secs    = '0;
      mismatches      = 0;
    endfunction

    function void write_reg(logic [fis_pkg::CFG_INDEX_WIDTH-1:0] index,
                            fis_pkg::limit_t value);
      if (index == fis_pkg::REG_INDUCER_LIMIT) begin
        inducer_limit = value;
      end else if (index == fis_pkg::REG_IGNITOR_LIMIT) begin
        ignitor_limit = value;
      end
    endfunction

    function fis_pkg::limit_t time_left(fis_pkg::limit_t limit,
                                        logic [SECONDS_WIDTH-1:0] elapsed);
      return (elapsed >= limit) ? '0 : fis_pkg::limit_t'(limit - elapsed);
    endfunction

    function void note_request(logic [fis_pkg::IN_DATA_WIDTH-1:0] data);
      logic             btn, pres, flame_lvl, flame, tick;
      logic             ind_on, ign_on, gas, blower;
      fis_pkg::result_t want;
      btn       = data[0];
      pres      = data[1];
      flame_lvl = data[2];
      flame     = !flame_lvl;
      tick      = data[3];
      ind_on    = 1'b0;
      ign_on    = 1'b0;
      gas       = 1'b0;
      blower    = 1'b0;

      if (tick) begin
        if (inducer_started && inducer_secs != '1) inducer_secs++;
        if (ignitor_started && ignitor_secs != '1) ignitor_secs++;
      end

      if (last_button && !btn) run_flag = !run_flag;

      if (run_flag) begin
        if (!inducer_started || inducer_secs < inducer_limit || pres) begin
          ind_on = 1'b1;
          if (!inducer_started) begin
            inducer_started = 1'b1;
            inducer_secs    = '0;
          end
        end else begin
          run_flag = 1'b0;
        end

        if (ind_on && pres && (!ignitor_started || ignitor_secs < ignitor_limit)) begin
          if (!ignitor_started) begin
            ignitor_started = 1'b1;
            ignitor_secs    = '0;
          end
          ign_on = 1'b1;
        end

        if (pres && ((ign_on && ignitor_secs > (ignitor_limit >> 1)) || flame)) begin
          gas = 1'b1;
        end else if (last_gas_open) begin
          run_flag = 1'b0;
        end

        blower = pres && flame;

        // gas left open with the ignitor off and no flame
        if (last_gas_open && !last_ignitor_on && !flame) run_flag = 1'b0;
        // flame lost
        if (!last_flame_lvl && !flame) run_flag = 1'b0;
      end

      if (!run_flag) begin
        ind_on          = 1'b0;
        ign_on          = 1'b0;
        gas             = 1'b0;
        blower          = 1'b0;
        inducer_started = 1'b0;
        inducer_secs    = '0;
        ignitor_started = 1'b0;
        ignitor_secs    = '0;
      end

      want.phase_code   = fis_pkg::PHASE_IDLE;
      want.seconds_left = '0;
      if (ind_on && !pres) begin
        want.phase_code   = fis_pkg::PHASE_PRESSURE;
        want.seconds_left = time_left(inducer_limit, inducer_secs);
      end else if (ign_on && !gas) begin
        want.phase_code   = fis_pkg::PHASE_WARMUP;
        want.seconds_left = time_left(ignitor_limit >> 1, ignitor_secs);
      end else if (ign_on && gas && !flame) begin
        want.phase_code   = fis_pkg::PHASE_START;
        want.seconds_left = time_left(ignitor_limit, ignitor_secs);
      end else if (pres && flame && blower && gas) begin
        want.phase_code = fis_pkg::PHASE_BURNING;
      end

      last_button     = btn;
      last_flame_lvl  = flame_lvl;
      last_gas_open   = gas;
      last_ignitor_on = ign_on;

      want.inducer_on     = ind_on;
      want.ignitor_on     = ign_on;
      want.gas_valve_open = gas;
      want.blower_on      = blower;
      want.running        = run_flag;
      expected_relays.push_back(want);
    endfunction

    function void compare_field(string name, int want, int seen);
      if (want != seen) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(logic [fis_pkg::OUT_DATA_WIDTH-1:0] data);
      fis_pkg::result_t seen, want;
      seen = fis_pkg::result_t'(data);
      if (expected_relays.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, expected none actual %h", $time, data);
      end else begin
        want = expected_relays.pop_front();
        compare_field("inducer_on", want.inducer_on, seen.inducer_on);
        compare_field("ignitor_on", want.ignitor_on, seen.ignitor_on);
        compare_field("gas_valve_open", want.gas_valve_open, seen.gas_valve_open);
        compare_field("blower_on", want.blower_on, seen.blower_on);
        compare_field("running", want.running, seen.running);
        compare_field("phase_code", want.phase_code, seen.phase_code);
        compare_field("seconds_left", want.seconds_left, seen.seconds_left);
      end
    endfunction
  endclass

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                s_tvalid  = 1'b0;
  logic                                s_tready;
  logic [fis_pkg::IN_DATA_WIDTH-1:0]   s_tdata   = '0;
  logic                                m_tvalid;
  logic                                m_tready  = 1'b0;
  logic [fis_pkg::OUT_DATA_WIDTH-1:0]  m_tdata;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [fis_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [fis_pkg::CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

  relay_scoreboard sb;
  int              requests_sent = 0;
  int              tick_pct      = 70;
  bit              source_gaps   = 1'b1;
  bit              sink_stalls   = 1'b1;

  furnace_ignition_sequencer_core #(
    .SECONDS_WIDTH(SECONDS_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // mostly short, now and then long
  function automatic int random_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic rand_tick();
    return $urandom_range(0, 99) < tick_pct;
  endfunction

  // {tick, flame_level, pressure_level, button_level}
  function automatic logic [3:0] pins(logic btn, logic pres, logic flame_lvl, logic tick);
    return {tick, flame_lvl, pres, btn};
  endfunction

  // tvalid stays high between back-to-back requests
  task automatic send_request(input logic [3:0] bits);
    int gap;
    gap = (source_gaps && $urandom_range(0, 99) < 30) ? random_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(fis_pkg::IN_DATA_WIDTH-4){1'b0}}, bits};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request({{(fis_pkg::IN_DATA_WIDTH-4){1'b0}}, bits});
    requests_sent++;
  endtask

  task automatic hold_pins(input logic btn, pres, flame_lvl, input int ticks);
    logic tick;
    while (ticks > 0) begin
      tick = rand_tick();
      send_request(pins(btn, pres, flame_lvl, tick));
      if (tick) ticks--;
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_request(4'($urandom_range(0, 15)));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_relays.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic change_limits(input fis_pkg::limit_t inducer_s,
                               input fis_pkg::limit_t ignitor_s);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= fis_pkg::REG_INDUCER_LIMIT;
    cfg_data  <= inducer_s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(fis_pkg::REG_INDUCER_LIMIT, inducer_s);
    cfg_index <= fis_pkg::REG_IGNITOR_LIMIT;
    cfg_data  <= ignitor_s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(fis_pkg::REG_IGNITOR_LIMIT, ignitor_s);
    cfg_valid <= 1'b0;
  endtask

  task automatic ignition_attempt();
    int ending;
    int inducer_ticks;
    int ignitor_ticks;
    // release then press; press again if that stopped a running burner
    send_request(pins(1'b1, 1'b0, 1'b1, rand_tick()));
    send_request(pins(1'b0, 1'b0, 1'b1, rand_tick()));
    if (!sb.run_flag) begin
      send_request(pins(1'b1, 1'b0, 1'b1, rand_tick()));
      send_request(pins(1'b0, 1'b0, 1'b1, rand_tick()));
    end

    if ($urandom_range(0, 3) == 0 && (sb.inducer_limit <= 40 || $urandom_range(0, 2) == 0))
      inducer_ticks = $urandom_range(0, int'(sb.inducer_limit) + 2);
    else
      inducer_ticks = $urandom_range(0, 2);
    hold_pins(1'b1, 1'b0, 1'b1, inducer_ticks);

    ending = $urandom_range(0, 5);
    if (ending == 5 && (sb.ignitor_limit <= 40 || $urandom_range(0, 2) == 0))
      ignitor_ticks = int'(sb.ignitor_limit) + 2;
    else
      ignitor_ticks = $urandom_range(0, int'(sb.ignitor_limit >> 1) + 2);
    hold_pins(1'b1, 1'b1, 1'b1, ignitor_ticks);

    if (ending != 5) hold_pins(1'b1, 1'b1, 1'b0, $urandom_range(0, 12));

    case (ending)
      0: begin
        send_request(pins(1'b0, 1'b1, 1'b0, rand_tick()));
        send_request(pins(1'b1, 1'b1, 1'b0, rand_tick()));
      end
      1: send_request(pins(1'b1, 1'b0, 1'b0, rand_tick()));
      2: send_request(pins(1'b1, 1'b1, 1'b1, rand_tick()));
      3: send_request(pins(1'b1, 1'b0, 1'b1, rand_tick()));
      default: ;
    endcase
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) begin
      source_gaps = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      tick_pct    = $urandom_range(40, 95);
      if ($urandom_range(0, 4) == 0)
        send_noise($urandom_range(1, 12));
      else
        ignition_attempt();
    end
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 99) < 25) stall_left = random_gap();
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [3:0] opening [0:24];
    // {tick, flame_level, pressure_level, button_level}
    opening = '{
      4'b0101,                            // idle
      4'b0100,                            // press: start, building pressure
      4'b1101,
      4'b1111,                            // pressure: ignitor warms up
      4'b1111, 4'b1111, 4'b1111, 4'b1111,
      4'b1111, 4'b1111, 4'b1111, 4'b1111, // past half time: gas opens
      4'b0011,                            // flame: burning
      4'b1011,
      4'b0010,                            // press while burning: all off
      4'b0011,
      4'b0100,                            // restart without pressure
      4'b1101, 4'b1101, 4'b1101,
      4'b1101, 4'b1101, 4'b1101,          // inducer time runs out
      4'b1111,
      4'b0000
    };
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_request(opening[i]);
    run_phase(180);

    change_limits(8'd0, 8'd0);
    run_phase(150);
    change_limits(8'd1, 8'd2);
    run_phase(180);
    change_limits(8'd255, 8'd255);
    run_phase(300);
    change_limits(fis_pkg::limit_t'($urandom_range(1, 8)),
                  fis_pkg::limit_t'($urandom_range(2, 16)));
    run_phase(250);
    change_limits(fis_pkg::limit_t'($urandom_range(0, 255)),
                  fis_pkg::limit_t'($urandom_range(0, 255)));
    run_phase(150);

    drain();
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
